// ----- hdl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

// ----- hdl/c3ks_pkg.sv -----
// shared constants, types and kernel table for the 3x3 convolution block
`timescale 1ns / 1ps

package c3ks_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int KERNEL_SIZE = 3;
  localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;

  localparam int PIX_W      = 8;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int SUM_W      = 14;
  localparam int WGT_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int BLUR_SHIFT = 4;

  typedef enum logic [1:0] {
    MODE_SOBEL_V,
    MODE_SOBEL_H,
    MODE_SHARPEN,
    MODE_BLUR
  } filter_mode_e;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  // window taps, row major, tap 0 is top row column x-2
  typedef logic [TAPS-1:0][PIX_W-1:0] window_t;

  // blur weights are applied unscaled, the divide by 16 follows the sum
  localparam logic signed [WGT_W-1:0] KERNELS [4][TAPS] = '{
    '{-4'sd1,  4'sd0,  4'sd1, -4'sd2,  4'sd0,  4'sd2, -4'sd1,  4'sd0,  4'sd1},
    '{-4'sd1, -4'sd2, -4'sd1,  4'sd0,  4'sd0,  4'sd0,  4'sd1,  4'sd2,  4'sd1},
    '{ 4'sd0, -4'sd1,  4'sd0, -4'sd1,  4'sd5, -4'sd1,  4'sd0, -4'sd1,  4'sd0},
    '{ 4'sd1,  4'sd2,  4'sd1,  4'sd2,  4'sd4,  4'sd2,  4'sd1,  4'sd2,  4'sd1}
  };

endpackage

// ----- hdl/c3ks_kernel_sum.sv -----
// nine-tap weighted sum of a 3x3 window with the selected kernel
`timescale 1ns / 1ps

module c3ks_kernel_sum import c3ks_pkg::*; (
  input  window_t                  win_i,
  input  filter_mode_e             mode_i,
  output logic signed [SUM_W-1:0]  sum_o
);

  logic signed [SUM_W-1:0] prod [TAPS];

  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      prod[i] = $signed({{(SUM_W-PIX_W){1'b0}}, win_i[i]}) * SUM_W'(KERNELS[mode_i][i]);
    end
  end

  // balanced adder tree
  assign sum_o = ((prod[0] + prod[1]) + (prod[2] + prod[3]))
               + ((prod[4] + prod[5]) + (prod[6] + prod[7]))
               + prod[8];

endmodule

// ----- hdl/conv3x3_kernel_select.sv -----
// top level: line store memory, 3x3 window and result pipeline
// a result is registered in stage 1, then stage 2, then the output register after its pixel is accepted
// throughput: one pixel per cycle while the output is not stalled, set by the read-modify-write of the line memory
// border pixels give no result; a stalled output holds the pipeline behind it
// reset: counters, window and valid bits cleared, registers to blur / 640 / 480
// reset: the line memory is not cleared, no clearing pass is needed
`timescale 1ns / 1ps

`include "assert_macros.svh"

module conv3x3_kernel_select import c3ks_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIX_W-1:0]      pixel_in_i,
  input  logic                  frame_first_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIX_W-1:0]      pixel_out_o,
  output logic [COL_W-1:0]      out_x_o,
  output logic [ROW_W-1:0]      out_y_o,
  output logic                  out_last_o
);

  // configuration
  filter_mode_e        mode_q;
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_BLUR;
      width_q  <= WIDTH_W'(640);
      height_q <= HEIGHT_W'(480);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FILTER_MODE:  mode_q   <= filter_mode_e'(cfg_wdata_i[1:0]);
        CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff = (width_q < WIDTH_W'(KERNEL_SIZE)) ? WIDTH_W'(KERNEL_SIZE) :
                 (width_q > WIDTH_W'(MAX_WIDTH))   ? WIDTH_W'(MAX_WIDTH) : width_q;
  assign h_eff = (height_q < HEIGHT_W'(KERNEL_SIZE)) ? HEIGHT_W'(KERNEL_SIZE) :
                 (height_q > HEIGHT_W'(MAX_HEIGHT))  ? HEIGHT_W'(MAX_HEIGHT) : height_q;

  // pipeline control
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic s1_emit_q;
  logic s2_adv_ok, s2_free, s1_retire, s1_free, in_fire;

  assign s2_adv_ok  = !out_valid_q || out_ready_i;
  assign s2_free    = !s2_valid_q || s2_adv_ok;
  assign s1_retire  = s1_valid_q && (!s1_emit_q || s2_free);
  assign s1_free    = !s1_valid_q || s1_retire;
  assign in_ready_o = s1_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // position of the request being accepted
  logic [COL_W-1:0]    col_q, col_d, cur_x;
  logic [ROW_W-1:0]    row_q, row_d, cur_y;
  logic [WIDTH_W-1:0]  x_inc;
  logic [HEIGHT_W-1:0] y_inc;
  logic                row_end, frame_end, emit_d, last_d;

  always_comb begin
    cur_x     = frame_first_i ? '0 : col_q;
    cur_y     = frame_first_i ? '0 : row_q;
    x_inc     = {1'b0, cur_x} + WIDTH_W'(1);
    y_inc     = {1'b0, cur_y} + HEIGHT_W'(1);
    row_end   = x_inc >= w_eff;
    frame_end = y_inc >= h_eff;
    col_d     = row_end ? '0 : x_inc[COL_W-1:0];
    row_d     = !row_end ? cur_y : (frame_end ? '0 : y_inc[ROW_W-1:0]);
    emit_d    = (cur_x >= COL_W'(KERNEL_SIZE - 1)) && (cur_y >= ROW_W'(KERNEL_SIZE - 1));
    last_d    = (x_inc == w_eff) && (y_inc == h_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1: line memory read data arrives, window completes
  logic [PIX_W-1:0] s1_pix_q;
  logic [COL_W-1:0] s1_idx_q, s1_x_q;
  logic [ROW_W-1:0] s1_y_q;
  logic             s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q  <= pixel_in_i;
      s1_idx_q  <= cur_x;
      s1_x_q    <= cur_x - COL_W'(1);
      s1_y_q    <= cur_y - ROW_W'(1);
      s1_emit_q <= emit_d;
      s1_last_q <= last_d;
    end
  end

  // line memory entry: upper byte row y-2, lower byte row y-1
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q, fwd_data_q, line_word;
  logic               fwd_q;
  logic [PIX_W-1:0]   line_top, line_mid;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_q <= line_mem[cur_x];
    end
    if (s1_retire) begin
      line_mem[s1_idx_q] <= {line_mid, s1_pix_q};
    end
  end

  // write-through forward when the retiring request writes the entry being read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_fire) begin
      fwd_q <= s1_retire && (s1_idx_q == cur_x);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fwd_data_q <= {line_mid, s1_pix_q};
    end
  end

  assign line_word = fwd_q ? fwd_data_q : rd_q;
  assign line_top  = line_word[2*PIX_W-1:PIX_W];
  assign line_mid  = line_word[PIX_W-1:0];

  // window columns x-2 (0..2) and x-1 (3..5), top to bottom
  logic [PIX_W-1:0] win_q [6];
  window_t          win;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_retire) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= line_top;
      win_q[4] <= line_mid;
      win_q[5] <= s1_pix_q;
    end
  end

  always_comb begin
    win[0] = win_q[0]; win[1] = win_q[3]; win[2] = line_top;
    win[3] = win_q[1]; win[4] = win_q[4]; win[5] = line_mid;
    win[6] = win_q[2]; win[7] = win_q[5]; win[8] = s1_pix_q;
  end

  logic signed [SUM_W-1:0] sum_d;

  c3ks_kernel_sum u_kernel_sum (
    .win_i  (win),
    .mode_i (mode_q),
    .sum_o  (sum_d)
  );

  // stage 2: scale and saturate
  logic signed [SUM_W-1:0] s2_sum_q, scaled;
  logic                    s2_blur_q, s2_last_q;
  logic [COL_W-1:0]        s2_x_q;
  logic [ROW_W-1:0]        s2_y_q;
  logic [PIX_W-1:0]        pix_sat_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= s1_retire && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && s1_retire && s1_emit_q) begin
      s2_sum_q  <= sum_d;
      s2_blur_q <= (mode_q == MODE_BLUR);
      s2_x_q    <= s1_x_q;
      s2_y_q    <= s1_y_q;
      s2_last_q <= s1_last_q;
    end
  end

  always_comb begin
    scaled = s2_blur_q ? (s2_sum_q >>> BLUR_SHIFT) : s2_sum_q;
    if (scaled < 0) begin
      pix_sat_d = '0;
    end else if (scaled > SUM_W'(255)) begin
      pix_sat_d = '1;
    end else begin
      pix_sat_d = scaled[PIX_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_adv_ok) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv_ok && s2_valid_q) begin
      pixel_out_o <= pix_sat_d;
      out_x_o     <= s2_x_q;
      out_y_o     <= s2_y_q;
      out_last_o  <= s2_last_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_CLK(a_out_interior, out_valid_o |-> (out_x_o != '0) && (out_y_o != '0), "border pixel emitted")
  `ASSERT_CLK(a_s2_hold, (s2_valid_q && !s2_adv_ok) |=> (s2_valid_q && $stable(s2_sum_q)), "stage 2 result lost while stalled")
  `ASSERT_NEVER(a_s1_overrun, in_fire && s1_valid_q && !s1_retire, "request accepted over a held stage 1 request")

endmodule

// ----- test/conv3x3_checker.sv -----
// checker: predicts the filtered pixel stream of the 3x3 convolution block and compares results
`timescale 1ns / 1ps

module conv3x3_checker import c3ks_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [PIX_W-1:0]      pixel_in_i,
  input  logic                  frame_first_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [PIX_W-1:0]      pixel_out_i,
  input  logic [COL_W-1:0]      out_x_i,
  input  logic [ROW_W-1:0]      out_y_i,
  input  logic                  out_last_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o
);

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [COL_W-1:0] x;
    logic [ROW_W-1:0] y;
    logic             last;
  } filtered_pix_t;

  filtered_pix_t filtered_q [$];

  filter_mode_e         mode;
  logic [WIDTH_W-1:0]   width_q;
  logic [HEIGHT_W-1:0]  height_q;

  // row_m1 holds the row above, row_m2 the one above that
  logic [PIX_W-1:0] row_m1 [MAX_WIDTH];
  logic [PIX_W-1:0] row_m2 [MAX_WIDTH];
  // columns x-2 and x-1, each top, middle, bottom
  logic [PIX_W-1:0] win_q [6];
  int col, row;
  int errors, checked, k;

  assign fail_count_o = errors;
  assign checked_o    = checked;

  function automatic int used_size(input int v, input int hi);
    return (v < KERNEL_SIZE) ? KERNEL_SIZE : ((v > hi) ? hi : v);
  endfunction

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    errors++;
    $display("%0t: %s expected %0d got %0d", $time, what, want, got);
  endtask

  task automatic advance_raster(input logic [PIX_W-1:0] p, input logic first);
    int ew, eh, x, y, acc;
    int taps [9];
    logic [PIX_W-1:0] top, mid;
    filtered_pix_t want;
    ew = used_size(int'(width_q), MAX_WIDTH);
    eh = used_size(int'(height_q), MAX_HEIGHT);
    if (first) begin
      col = 0;
      row = 0;
    end
    x = col;
    y = row;
    top = row_m2[x];
    mid = row_m1[x];
    taps[0] = win_q[0]; taps[1] = win_q[3]; taps[2] = top;
    taps[3] = win_q[1]; taps[4] = win_q[4]; taps[5] = mid;
    taps[6] = win_q[2]; taps[7] = win_q[5]; taps[8] = p;

    if (x >= 2 && y >= 2) begin
      case (mode)
        MODE_SOBEL_V: acc = taps[2] + 2 * taps[5] + taps[8] - taps[0] - 2 * taps[3] - taps[6];
        MODE_SOBEL_H: acc = taps[6] + 2 * taps[7] + taps[8] - taps[0] - 2 * taps[1] - taps[2];
        MODE_SHARPEN: acc = 5 * taps[4] - taps[1] - taps[3] - taps[5] - taps[7];
        MODE_BLUR:    acc = (taps[0] + taps[2] + taps[6] + taps[8]
                             + 2 * (taps[1] + taps[3] + taps[5] + taps[7]) + 4 * taps[4]) / 16;
      endcase
      if (acc < 0) acc = 0;
      else if (acc > 255) acc = 255;
      want.value = PIX_W'(acc);
      want.x     = COL_W'(x - 1);
      want.y     = ROW_W'(y - 1);
      want.last  = (x + 1 == ew) && (y + 1 == eh);
      filtered_q.push_back(want);
    end

    row_m2[x] = mid;
    row_m1[x] = p;
    win_q[0] = win_q[3];
    win_q[1] = win_q[4];
    win_q[2] = win_q[5];
    win_q[3] = top;
    win_q[4] = mid;
    win_q[5] = p;

    if (x + 1 >= ew) begin
      col = 0;
      row = (y + 1 >= eh) ? 0 : y + 1;
    end else begin
      col = x + 1;
    end
  endtask

  task automatic compare_result();
    filtered_pix_t want;
    checked++;
    if (filtered_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, got pixel %0d at (%0d,%0d) last %0d",
               $time, pixel_out_i, out_x_i, out_y_i, out_last_i);
    end else begin
      want = filtered_q.pop_front();
      if (pixel_out_i !== want.value) report("pixel_out", want.value, pixel_out_i);
      if (out_x_i !== want.x) report("out_x", want.x, out_x_i);
      if (out_y_i !== want.y) report("out_y", want.y, out_y_i);
      if (out_last_i !== want.last) report("out_last", want.last, out_last_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode     = MODE_BLUR;
      width_q  = WIDTH_W'(640);
      height_q = HEIGHT_W'(480);
      for (k = 0; k < MAX_WIDTH; k++) begin
        row_m1[k] = '0;
        row_m2[k] = '0;
      end
      for (k = 0; k < 6; k++) win_q[k] = '0;
      col = 0;
      row = 0;
      filtered_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) compare_result();
      if (in_valid_i && in_ready_i) advance_raster(pixel_in_i, frame_first_i);
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_FILTER_MODE:  mode = filter_mode_e'(cfg_wdata_i[1:0]);
          CFG_IMAGE_WIDTH:  width_q = cfg_wdata_i[WIDTH_W-1:0];
          CFG_IMAGE_HEIGHT: height_q = cfg_wdata_i[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      pending_o <= filtered_q.size();
    end
  end

  initial begin
    errors  = 0;
    checked = 0;
  end

endmodule

// ----- test/tb.sv -----
// testbench top: clock, reset, pixel stream and register stimulus, final verdict
`timescale 1ns / 1ps

module tb;
  import c3ks_pkg::*;

  // index past the register list, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam int RANDOM_ITEMS = 640;
  localparam int QUIET_FROM   = 540;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [PIX_W-1:0]      pixel_in_i;
  logic                  frame_first_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [PIX_W-1:0]      pixel_out_o;
  logic [COL_W-1:0]      out_x_o;
  logic [ROW_W-1:0]      out_y_o;
  logic                  out_last_o;

  int fail_count, pending, checked;
  int sent, random_sent, settings_used, cycle_count;
  int cur_w;
  bit quiet, gaps_on;

  always #1 clk_i = ~clk_i;

  conv3x3_kernel_select DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .pixel_in_i, .frame_first_i,
    .out_valid_o, .out_ready_i, .pixel_out_o, .out_x_o, .out_y_o, .out_last_o
  );

  conv3x3_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i,
    .in_ready_i    (in_ready_o),
    .pixel_in_i, .frame_first_i,
    .out_valid_i   (out_valid_o),
    .out_ready_i,
    .pixel_out_i   (pixel_out_o),
    .out_x_i       (out_x_o),
    .out_y_i       (out_y_o),
    .out_last_i    (out_last_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  function automatic int used_size(input int v, input int hi);
    return (v < KERNEL_SIZE) ? KERNEL_SIZE : ((v > hi) ? hi : v);
  endfunction

  // saturating values show up more often than uniform noise would give
  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_width();
    case ($urandom_range(0, 9))
      0: return CFG_DATA_W'($urandom_range(0, 2));
      1, 2: return CFG_DATA_W'($urandom_range(13, 40));
      // upper bits fall outside the register and are dropped
      3: return 13'h1800 | CFG_DATA_W'($urandom_range(3, 12));
      default: return CFG_DATA_W'($urandom_range(3, 12));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_height();
    case ($urandom_range(0, 9))
      0: return CFG_DATA_W'($urandom_range(0, 2));
      1: return $urandom_range(0, 1) ? CFG_DATA_W'(MAX_HEIGHT) : 13'h1FFF;
      2: return CFG_DATA_W'($urandom_range(9, 20));
      default: return CFG_DATA_W'($urandom_range(3, 8));
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] value, input logic first);
    if (gaps_on && !quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_in_i    <= value;
    frame_first_i <= first;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
  endtask

  // caller lowers the write enable after the last write
  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input filter_mode_e mode, input logic [CFG_DATA_W-1:0] w,
                              input logic [CFG_DATA_W-1:0] h);
    reg_write(CFG_FILTER_MODE, CFG_DATA_W'(mode));
    reg_write(CFG_IMAGE_WIDTH, w);
    reg_write(CFG_IMAGE_HEIGHT, h);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // registers may only change once the pipeline is empty
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
    $display("FAIL conv3x3_kernel_select");
    $finish;
  end

  initial begin
    int i, span, cur_h;
    bit fresh;
    logic [CFG_DATA_W-1:0] w_reg, h_reg;

    sent          = 0;
    random_sent   = 0;
    settings_used = 0;
    quiet         = 1'b0;
    gaps_on       = 1'b0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CFG_FILTER_MODE;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    pixel_in_i    <= '0;
    frame_first_i <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 3x3 frames: width given with stray upper bits, height below the minimum
    program_regs(MODE_SHARPEN, 13'h1803, 13'd1);
    // bright ring around a dark centre drives sharpen below zero
    for (i = 0; i < 9; i++) send_pixel((i == 4) ? 8'd0 : 8'd255, i == 0);
    wait_drained();
    reg_write(CFG_SPARE_IDX, 13'h1FFF);
    cfg_we_i <= 1'b0;
    // no frame start mark: position wraps after the first frame, sharpen overflows high
    for (i = 0; i < 9; i++) send_pixel((i == 4) ? 8'd255 : 8'd0, 1'b0);
    wait_drained();

    // one full row at the widest setting and the start of the next, width masked then clamped
    gaps_on = 1'b1;
    program_regs(MODE_SOBEL_V, 13'h1FFF, 13'd3);
    for (i = 0; i < MAX_WIDTH + 16; i++) send_pixel(pick_pixel(), i == 0);
    cur_w = MAX_WIDTH;

    while (random_sent < RANDOM_ITEMS) begin
      wait_drained();
      // a continued frame may shrink its rows but never widen them
      fresh = $urandom_range(0, 1);
      if (fresh) w_reg = pick_width();
      else w_reg = CFG_DATA_W'($urandom_range(0, (cur_w < 40) ? cur_w : 40));
      h_reg = pick_height();
      program_regs(filter_mode_e'($urandom_range(0, 3)), w_reg, h_reg);
      cur_w = used_size(int'(w_reg[WIDTH_W-1:0]), MAX_WIDTH);
      cur_h = used_size(int'(h_reg), MAX_HEIGHT);
      span = cur_w * cur_h * $urandom_range(1, 2);
      if (span > 300) span = 300;
      if ($urandom_range(0, 3) == 0) span = $urandom_range(1, span);
      gaps_on = ($urandom_range(0, 3) != 0);
      for (i = 0; i < span; i++) begin
        if (random_sent >= QUIET_FROM) quiet = 1'b1;
        send_pixel(pick_pixel(), (fresh && i == 0) || $urandom_range(0, 99) == 0);
        random_sent++;
      end
    end
    wait_drained();

    $display("sent %0d pixels under %0d register settings, %0d filtered pixels compared",
             sent, settings_used, checked);
    $display("widths 3 to %0d, all four kernels, mid-frame restarts and resizes", MAX_WIDTH);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS conv3x3_kernel_select");
    end else begin
      $display("FAIL conv3x3_kernel_select");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/c3ks_pkg.sv
hdl/c3ks_kernel_sum.sv
hdl/conv3x3_kernel_select.sv
test/conv3x3_checker.sv
test/tb.sv
